@@ hdl/scfx_pkg.sv @@
// Shared constants and controller/datapath interface types for the frame extractor.
package scfx_pkg;

    localparam int FRAME_MAX = 32;
    localparam int BUF_DEPTH = FRAME_MAX - 1;
    localparam int CNT_W     = $clog2(FRAME_MAX);
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'd1;

    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'd35;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'd33;

    typedef struct packed {
        logic open_frame;
        logic store_byte;
        logic start_dump;
        logic load_out;
        logic advance;
        logic finish;
    } scfx_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_end;
        logic more;
        logic dropped;
    } scfx_sts_t;

endpackage

@@ hdl/scfx_dp.sv @@
// Datapath: configuration registers, frame buffer, fill count and output byte register.
module scfx_dp
    import scfx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]    in_byte,
    input  scfx_cmd_t            cmd,
    output scfx_sts_t            sts,
    output logic [BYTE_W-1:0]    out_byte
);

    logic [BYTE_W-1:0] start_char_reg;
    logic [BYTE_W-1:0] end_char_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic [CNT_W-1:0]  fill_count_next;
    logic [CNT_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  rd_ptr_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              full;
    logic [BYTE_W-1:0] frame_mem [BUF_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_char_reg <= START_CHAR_RST;
            end_char_reg   <= END_CHAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_CHAR: start_char_reg <= cfg_data;
                REG_END_CHAR:   end_char_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign full         = (fill_count_reg == CNT_W'(BUF_DEPTH));
    assign sts.is_start = (in_byte == start_char_reg);
    assign sts.is_end   = (in_byte == end_char_reg);
    assign sts.more     = (rd_ptr_reg < fill_count_reg);
    assign sts.dropped  = dropped_reg;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        rd_ptr_next     = rd_ptr_reg;
        if (cmd.open_frame)
        begin
            fill_count_next = CNT_W'(1);
            dropped_next    = 1'b0;
        end
        else if (cmd.store_byte)
        begin
            if (full)
                dropped_next = 1'b1;
            else
                fill_count_next = fill_count_reg + CNT_W'(1);
        end
        if (cmd.start_dump)
            rd_ptr_next = '0;
        else if (cmd.advance)
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        if (cmd.finish)
        begin
            fill_count_next = '0;
            dropped_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    // The start byte always lands at the base of the buffer.
    always_ff @(posedge clk)
    begin
        if (cmd.open_frame)
            frame_mem[0] <= in_byte;
        else if (cmd.store_byte && !full)
            frame_mem[fill_count_reg[ADDR_W-1:0]] <= in_byte;
    end

    // Once the stored bytes are exhausted, the end byte is the end character itself.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (sts.more)
                out_byte_reg <= frame_mem[rd_ptr_reg[ADDR_W-1:0]];
            else
                out_byte_reg <= end_char_reg;
        end
    end

    assign out_byte = out_byte_reg;

endmodule

@@ hdl/scfx_ctrl.sv @@
// Controller: frame reception and dump sequencing state machine.
module scfx_ctrl
    import scfx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    output logic      out_last,
    input  logic      out_ready,
    input  scfx_sts_t sts,
    output scfx_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RECV = 3'd1;
    localparam logic [2:0] S_DUMP = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_RECV);
    assign out_valid = (state_reg == S_OUT) || (state_reg == S_LAST);
    assign out_last  = (state_reg == S_LAST);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && sts.is_start)
                begin
                    cmd.open_frame = 1'b1;
                    state_next     = S_RECV;
                end
            end
            S_RECV:
            begin
                if (in_xfer)
                begin
                    // A start character wins over the end character when both match.
                    if (sts.is_start)
                        cmd.open_frame = 1'b1;
                    else if (sts.is_end)
                    begin
                        cmd.start_dump = 1'b1;
                        state_next     = S_DUMP;
                    end
                    else
                        cmd.store_byte = 1'b1;
                end
            end
            S_DUMP:
            begin
                cmd.load_out = 1'b1;
                state_next   = sts.more ? S_OUT : S_LAST;
            end
            S_OUT:
            begin
                if (out_xfer)
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_DUMP;
                end
            end
            S_LAST:
            begin
                if (out_xfer)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ hdl/start_signal_char_frame_extractor_top.sv @@
// Top level of the start/end character frame extractor.
//
// Usage: received bytes enter on the s_axis channel, one byte per transfer.
// Bytes are discarded until the start character arrives; the start byte and
// the bytes after it are held in a 31-byte buffer. When the end character
// arrives, the frame from start byte through end byte leaves on the m_axis
// channel, one byte per transfer, with tlast on the end byte and tuser set
// on every byte of a frame that lost bytes to a full buffer.
// The cfg channel writes start_char (index 0) and end_char (index 1); it is
// always ready. The user must write it only while no frame is being emitted;
// the block itself does not enforce this. A byte that does not close a frame
// is accepted without stalling. A closing byte is followed by a dump of n+1
// output transfers, n the stored byte count; each one reads the buffer into
// the output register, then makes the transfer, since the buffer has a single
// read port. s_tready is low during the dump.
// Reset returns to idle with an empty buffer and the default characters
// '#' and '!'. A stalled receiver simply holds the output byte in place.
module start_signal_char_frame_extractor_top
    import scfx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [7:0] frame_byte
    output logic                 m_tlast,
    output logic                 m_tuser,    // [0] frame_overflow
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    scfx_cmd_t cmd;
    scfx_sts_t sts;

    assign cfg_ready = 1'b1;
    assign m_tuser   = sts.dropped;

    scfx_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_last  (m_tlast),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scfx_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_byte  (m_tdata)
    );

endmodule
